// File: rtl/alt_pkg.sv
package alt_pkg;

  localparam int LINE_BITS_DEFAULT   = 16;
  localparam int COLUMN_BITS_DEFAULT = 12;
  localparam int RQ_DEPTH_DEFAULT    = 4;

  localparam logic [7:0] COMMENT_RESET = 8'd59;
  localparam logic [7:0] QUOTE_BYTE    = 8'd34;
  localparam logic [7:0] COMMA_BYTE    = 8'd44;
  localparam logic [7:0] NEWLINE_BYTE  = 8'd10;
  localparam logic [7:0] TAB_BYTE      = 8'd9;
  localparam logic [7:0] CR_BYTE       = 8'd13;
  localparam logic [7:0] SPACE_BYTE    = 8'd32;

  typedef enum logic [1:0] {
    KIND_TOKEN_BYTE  = 2'd0,
    KIND_TOKEN_END   = 2'd1,
    KIND_LINE_RECORD = 2'd2,
    KIND_ERROR       = 2'd3
  } kind_t;

  typedef enum logic {
    ERR_EMPTY_LITERAL = 1'b0,
    ERR_UNTERMINATED  = 1'b1
  } err_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == SPACE_BYTE) || ((b >= TAB_BYTE) && (b <= CR_BYTE));
  endfunction

endpackage

// File: rtl/alt_if.sv
interface alt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface alt_out_if #(
  parameter int LINE_BITS   = alt_pkg::LINE_BITS_DEFAULT,
  parameter int COLUMN_BITS = alt_pkg::COLUMN_BITS_DEFAULT
);
  logic                   valid;
  logic                   ready;
  alt_pkg::kind_t         kind;
  logic [7:0]             token_byte;
  logic [LINE_BITS-1:0]   line_num;
  logic [COLUMN_BITS-1:0] lead_col;
  alt_pkg::err_t          error_code;
  logic                   last_of_run;

  modport source (output valid, output kind, output token_byte, output line_num,
                  output lead_col, output error_code, output last_of_run,
                  input ready);
  modport sink   (input valid, input kind, input token_byte, input line_num,
                  input lead_col, input error_code, input last_of_run,
                  output ready);
endinterface

// File: rtl/assembly_line_tokenizer_top.sv
// Streaming tokenizer for assembly source text.
// in_ch carries one source byte per transaction (text_byte) plus end_of_text,
// which closes any open line and returns the tokenizer to its reset state.
// out_ch carries one result per transaction: token byte, token end, line
// record (line number and leading-whitespace column) or error. A source byte
// gives zero, one or two results; last_of_run marks the final one.
// cfg_we/cfg_data write the comment character; write only while idle.
// Results of a byte go into the result queue when the byte is accepted and are
// offered on out_ch behind any earlier results. Throughput: one byte per cycle
// while each byte gives at most one result and out_ch is ready; the output port
// moves one result per cycle, so a byte with two results sends them in turn.
// A four-entry result queue sits between the tokenizer state and out_ch; when
// out_ch stalls, the queue fills and in_ch.ready drops once fewer than two
// entries are free, so no result is ever lost.
// Reset (rst_n low at a clock edge) empties the queue, clears all line and
// quote state, restarts line numbering and sets the comment character to ';'.
// After an error the block swallows bytes until end_of_text or reset.
module assembly_line_tokenizer_top #(
  parameter int LINE_BITS   = alt_pkg::LINE_BITS_DEFAULT,
  parameter int COLUMN_BITS = alt_pkg::COLUMN_BITS_DEFAULT,
  parameter int RQ_DEPTH    = alt_pkg::RQ_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  alt_in_if.sink     in_ch,
  alt_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  typedef struct packed {
    alt_pkg::kind_t         kind;
    logic [7:0]             token_byte;
    logic [LINE_BITS-1:0]   line_num;
    logic [COLUMN_BITS-1:0] lead_col;
    alt_pkg::err_t          error_code;
    logic                   last_of_run;
  } res_t;

  localparam int RES_W = $bits(res_t);

  logic [7:0]            cmt_byte_r;
  logic                  accept;
  logic [1:0]            push_n;
  logic [1:0][RES_W-1:0] push_data;
  logic                  space_ok;
  logic [RES_W-1:0]      head_data;
  res_t                  head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmt_byte_r <= alt_pkg::COMMENT_RESET;
    end else if (cfg_we) begin
      cmt_byte_r <= cfg_data;
    end
  end

  assign in_ch.ready = space_ok;
  assign accept      = in_ch.valid && space_ok;

  alt_core #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .text_byte    (in_ch.text_byte),
    .end_of_text  (in_ch.end_of_text),
    .cmt_byte     (cmt_byte_r),
    .push_n       (push_n),
    .push_data    (push_data)
  );

  alt_rqueue #(
    .WIDTH (RES_W),
    .DEPTH (RQ_DEPTH)
  ) u_rqueue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .push_data  (push_data),
    .space_ok   (space_ok),
    .head_valid (out_ch.valid),
    .pop        (out_ch.ready),
    .head_data  (head_data)
  );

  assign head               = head_data;
  assign out_ch.kind        = head.kind;
  assign out_ch.token_byte  = head.token_byte;
  assign out_ch.line_num    = head.line_num;
  assign out_ch.lead_col    = head.lead_col;
  assign out_ch.error_code  = head.error_code;
  assign out_ch.last_of_run = head.last_of_run;

endmodule

// File: rtl/alt_core.sv
module alt_core #(
  parameter int LINE_BITS   = alt_pkg::LINE_BITS_DEFAULT,
  parameter int COLUMN_BITS = alt_pkg::COLUMN_BITS_DEFAULT,
  localparam int RES_W      = 2 + 8 + LINE_BITS + COLUMN_BITS + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            text_byte,
  input  logic                  end_of_text,
  input  logic [7:0]            cmt_byte,
  output logic [1:0]            push_n,
  output logic [1:0][RES_W-1:0] push_data
);

  typedef struct packed {
    alt_pkg::kind_t         kind;
    logic [7:0]             token_byte;
    logic [LINE_BITS-1:0]   line_num;
    logic [COLUMN_BITS-1:0] lead_col;
    alt_pkg::err_t          error_code;
    logic                   last_of_run;
  } res_t;

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

  logic                   inside_quotes_r, inside_quotes_nxt;
  logic                   token_open_r, token_open_nxt;
  logic                   skipping_r, skipping_nxt;
  logic                   in_lead_r, in_lead_nxt;
  logic [COLUMN_BITS-1:0] lead_count_r, lead_count_nxt;
  logic [LINE_BITS-1:0]   line_count_r, line_count_nxt;
  logic                   halted_r, halted_nxt;

  logic [LINE_BITS-1:0] cur_line;
  logic                 sp;
  res_t                 base, r0, r1, q;
  logic                 q_valid;
  logic [1:0]           n;

  assign cur_line = (line_count_r == LINE_MAX) ? LINE_MAX : line_count_r + 1'b1;
  assign sp       = alt_pkg::is_space(text_byte);

  always_comb begin
    inside_quotes_nxt = inside_quotes_r;
    token_open_nxt    = token_open_r;
    skipping_nxt      = skipping_r;
    in_lead_nxt       = in_lead_r;
    lead_count_nxt    = lead_count_r;
    line_count_nxt    = line_count_r;
    halted_nxt        = halted_r;
    base              = '0;
    base.line_num     = cur_line;
    r0                = base;
    r1                = base;
    q                 = base;
    q_valid           = 1'b0;
    n                 = 2'd0;

    if (end_of_text || (!halted_r && text_byte == alt_pkg::NEWLINE_BYTE)) begin
      // close the line: an open literal is an error, an open token ends
      if (!halted_r) begin
        if (inside_quotes_r) begin
          r0.kind       = alt_pkg::KIND_ERROR;
          r0.error_code = alt_pkg::ERR_UNTERMINATED;
          n             = 2'd1;
        end else if (token_open_r) begin
          r0.kind = alt_pkg::KIND_TOKEN_END;
          n       = 2'd1;
        end
      end
      inside_quotes_nxt = 1'b0;
      token_open_nxt    = 1'b0;
      skipping_nxt      = 1'b0;
      in_lead_nxt       = 1'b1;
      lead_count_nxt    = '0;
      if (end_of_text) begin
        line_count_nxt = '0;
        halted_nxt     = 1'b0;
      end else begin
        if (line_count_r != LINE_MAX) line_count_nxt = line_count_r + 1'b1;
        halted_nxt = inside_quotes_r;
      end
    end else if (halted_r || skipping_r) begin
      n = 2'd0;
    end else if (text_byte == cmt_byte) begin
      skipping_nxt = 1'b1;
    end else if (in_lead_r && sp) begin
      if (lead_count_r != COL_MAX) lead_count_nxt = lead_count_r + 1'b1;
    end else begin
      if (inside_quotes_r) begin
        if (text_byte == alt_pkg::QUOTE_BYTE) begin
          q_valid = 1'b1;
          if (!token_open_r) begin
            q.kind       = alt_pkg::KIND_ERROR;
            q.error_code = alt_pkg::ERR_EMPTY_LITERAL;
            halted_nxt   = 1'b1;
          end else begin
            q.kind            = alt_pkg::KIND_TOKEN_END;
            token_open_nxt    = 1'b0;
            inside_quotes_nxt = 1'b0;
          end
        end else begin
          q.kind         = alt_pkg::KIND_TOKEN_BYTE;
          q.token_byte   = text_byte;
          q_valid        = 1'b1;
          token_open_nxt = 1'b1;
        end
      end else if (text_byte == alt_pkg::QUOTE_BYTE || sp ||
                   text_byte == alt_pkg::COMMA_BYTE) begin
        if (token_open_r) begin
          q.kind         = alt_pkg::KIND_TOKEN_END;
          q_valid        = 1'b1;
          token_open_nxt = 1'b0;
        end
        if (text_byte == alt_pkg::QUOTE_BYTE) inside_quotes_nxt = 1'b1;
      end else begin
        q.kind         = alt_pkg::KIND_TOKEN_BYTE;
        q.token_byte   = text_byte;
        q_valid        = 1'b1;
        token_open_nxt = 1'b1;
      end

      // first content byte of the line: line record goes ahead of its tokens
      if (in_lead_r) begin
        in_lead_nxt = 1'b0;
        r0.kind     = alt_pkg::KIND_LINE_RECORD;
        r0.lead_col = lead_count_r;
        r1          = q;
        n           = q_valid ? 2'd2 : 2'd1;
      end else begin
        r0 = q;
        n  = q_valid ? 2'd1 : 2'd0;
      end
    end

    if (n == 2'd1) r0.last_of_run = 1'b1;
    if (n == 2'd2) r1.last_of_run = 1'b1;
  end

  assign push_n       = accept ? n : 2'd0;
  assign push_data[0] = r0;
  assign push_data[1] = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_quotes_r <= 1'b0;
      token_open_r    <= 1'b0;
      skipping_r      <= 1'b0;
      in_lead_r       <= 1'b1;
      lead_count_r    <= '0;
      line_count_r    <= '0;
      halted_r        <= 1'b0;
    end else if (accept) begin
      inside_quotes_r <= inside_quotes_nxt;
      token_open_r    <= token_open_nxt;
      skipping_r      <= skipping_nxt;
      in_lead_r       <= in_lead_nxt;
      lead_count_r    <= lead_count_nxt;
      line_count_r    <= line_count_nxt;
      halted_r        <= halted_nxt;
    end
  end

  a_lead_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_lead_r |-> (!inside_quotes_r && !token_open_r))
    else $error("token or literal open during leading whitespace");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && halted_r && !end_of_text) |-> (push_n == 2'd0))
    else $error("results produced while halted");

  a_push_max: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd3)
    else $error("more than two results for one transaction");

endmodule

// File: rtl/alt_rqueue.sv
module alt_rqueue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = alt_pkg::RQ_DEPTH_DEFAULT,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            push_n,
  input  logic [1:0][WIDTH-1:0] push_data,
  output logic                  space_ok,
  output logic                  head_valid,
  input  logic                  pop,
  output logic [WIDTH-1:0]      head_data
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(DEPTH - 2);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_1;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign do_pop     = pop && head_valid;
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign space_ok   = (count_r <= CNT_ROOM);
  assign wr_ptr_1   = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    case (push_n)
      2'd1:    wr_ptr_nxt = wr_ptr_1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push_n) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_ptr_r] <= push_data[0];
    if (push_n == 2'd2) mem_r[wr_ptr_1] <= push_data[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("result queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> space_ok)
    else $error("push into result queue without room");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && push_n == 2'd0) |=> (count_r == $past(count_r) - 1'b1))
    else $error("result queue count did not drop after pop");

endmodule
